FILE: hw/rtl/pci_bar_window_allocator_assert.svh
// Assertion macros used by the checker of the BAR allocator.
`ifndef PCI_BAR_WINDOW_ALLOCATOR_ASSERT_SVH
`define PCI_BAR_WINDOW_ALLOCATOR_ASSERT_SVH

// Clocked property, switched off while reset is high.
`define PBA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pba: property failed");

// Clocked property that also holds through reset.
`define PBA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pba: property failed through reset");

`endif

FILE: hw/rtl/pba_pkg.sv
package pba_pkg;

  localparam int BARS_PER_DEVICE_DEF = 6;

  localparam logic [31:0] ADDR_MASK  = 32'hFFFF_FFF0;
  localparam logic [31:0] SIZE_LIMIT = 32'h1000_0000;
  localparam logic [1:0]  TYPE_32    = 2'b00;
  localparam logic [1:0]  TYPE_64    = 2'b10;

  typedef enum logic [2:0] {
    ACT_KEPT     = 3'd0,
    ACT_UNIMPL   = 3'd1,
    ACT_UNSUP    = 3'd2,
    ACT_BAD_SIZE = 3'd3,
    ACT_ASSIGNED = 3'd4,
    ACT_UPPER    = 3'd5
  } pba_action_t;

  typedef struct packed {
    logic        start_of_run;
    logic [2:0]  bar_index;
    logic [31:0] orig_value;
    logic [31:0] probe_value;
  } pba_item_t;

  typedef struct packed {
    pba_action_t action;
    logic [31:0] write_value;
    logic [31:0] assigned_count;
    logic [31:0] next_free;
  } pba_result_t;

endpackage

FILE: hw/rtl/pba_if.sv
interface pba_item_if;
  logic        valid;
  logic        ready;
  logic        start_of_run;
  logic [2:0]  bar_index;
  logic [31:0] orig_value;
  logic [31:0] probe_value;

  modport source (output valid, start_of_run, bar_index, orig_value, probe_value,
                  input ready);
  modport sink (input valid, start_of_run, bar_index, orig_value, probe_value,
                output ready);
endinterface

interface pba_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [31:0] write_value;
  logic [31:0] assigned_count;
  logic [31:0] next_free;

  modport source (output valid, action, write_value, assigned_count, next_free,
                  input ready);
  modport sink (input valid, action, write_value, assigned_count, next_free,
                output ready);
endinterface

interface pba_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] window_base;

  modport source (output valid, window_base, input ready);
  modport sink (input valid, window_base, output ready);
endinterface

FILE: hw/rtl/pba_in_reg.sv
module pba_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  pba_pkg::pba_item_t d,
  input  logic              advance,
  output logic              valid,
  output pba_pkg::pba_item_t q
);
  import pba_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= d;
    end
  end

endmodule

FILE: hw/rtl/pba_alloc.sv
module pba_alloc #(
  parameter int BARS_PER_DEVICE = pba_pkg::BARS_PER_DEVICE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_data,
  input  logic                 advance,
  input  pba_pkg::pba_item_t   item,
  output pba_pkg::pba_result_t result
);
  import pba_pkg::*;

  logic [31:0] window_base;
  logic [31:0] cursor;
  logic [31:0] count;
  logic        upper_half_pending;

  logic [31:0] cursor_next;
  logic [31:0] count_next;
  logic        upper_half_pending_next;

  always_comb begin
    logic [31:0] cur;
    logic [31:0] cnt;
    logic        pend;
    logic [1:0]  kind;
    logic [31:0] size;
    logic [31:0] aligned;
    logic        room;

    cur  = item.start_of_run ? window_base : cursor;
    cnt  = item.start_of_run ? 32'd0 : count;
    pend = item.start_of_run ? 1'b0 : upper_half_pending;
    kind = item.probe_value[2:1];
    size = ~(item.probe_value & ADDR_MASK) + 32'd1;
    aligned = (cur + size - 32'd1) & ~(size - 32'd1);
    room = ({1'b0, item.bar_index} + 4'd1) < 4'(BARS_PER_DEVICE);

    cursor_next             = cur;
    count_next              = cnt;
    upper_half_pending_next = pend;
    result.action           = ACT_KEPT;
    result.write_value      = item.orig_value;

    if (pend) begin
      upper_half_pending_next = 1'b0;
      result.action           = ACT_UPPER;
      result.write_value      = 32'd0;
    end else if ((item.orig_value & ADDR_MASK) != 32'd0) begin
      result.action      = ACT_KEPT;
      result.write_value = item.orig_value;
    end else if (item.probe_value == 32'd0) begin
      result.action      = ACT_UNIMPL;
      result.write_value = item.probe_value;
    end else if (item.probe_value[0] || (kind != TYPE_32 && kind != TYPE_64)) begin
      result.action      = ACT_UNSUP;
      result.write_value = item.probe_value;
    end else if (size == 32'd0 || size > SIZE_LIMIT) begin
      result.action      = ACT_BAD_SIZE;
      result.write_value = item.orig_value;
    end else begin
      // place at the cursor rounded up to the size, then step past it
      cursor_next        = aligned + size;
      count_next         = cnt + 32'd1;
      upper_half_pending_next = (kind == TYPE_64) && room;
      result.action      = ACT_ASSIGNED;
      result.write_value = aligned | {28'd0, item.probe_value[3:0]};
    end

    result.assigned_count = count_next;
    result.next_free      = cursor_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_base        <= 32'd0;
      cursor             <= 32'd0;
      count              <= 32'd0;
      upper_half_pending <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_base <= cfg_data;
      end
      if (advance) begin
        cursor             <= cursor_next;
        count              <= count_next;
        upper_half_pending <= upper_half_pending_next;
      end
    end
  end

endmodule

FILE: hw/rtl/pba_out_reg.sv
module pba_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  pba_pkg::pba_result_t d,
  input  logic                 take,
  output logic                 valid,
  output pba_pkg::pba_result_t q
);
  import pba_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= d;
    end
  end

endmodule

FILE: hw/rtl/pci_bar_window_allocator.sv
// Channel   Dir  Word
// bars      in   start_of_run, bar_index, orig_value, probe_value
// results   out  action, write_value, assigned_count, next_free
// cfg       in   window_base
//
// One BAR word per cycle sustained while results is ready; a word taken from bars
// passes through the input register and then the result register, with the
// cursor update (align add, mask, advance add) between them.
// Reset clears the cursor, count, pending upper half and window_base.
// While results stalls, one further word is held in the input register.
// cfg is always ready.
module pci_bar_window_allocator #(
  parameter int BARS_PER_DEVICE = pba_pkg::BARS_PER_DEVICE_DEF
) (
  input logic         clk,
  input logic         rst,
  pba_item_if.sink    bars,
  pba_result_if.source results,
  pba_cfg_if.sink     cfg
);
  import pba_pkg::*;

  pba_item_t   in_word;
  pba_item_t   item;
  pba_result_t result;
  pba_result_t out_word;
  logic        in_valid;
  logic        out_valid;
  logic        advance;
  logic        load_in;

  assign in_word = '{start_of_run: bars.start_of_run, bar_index: bars.bar_index,
                     orig_value: bars.orig_value, probe_value: bars.probe_value};

  // move a word on when the result register is free or being drained
  assign advance    = in_valid && (!out_valid || results.ready);
  assign bars.ready = !in_valid || advance;
  assign load_in    = bars.valid && bars.ready;
  assign cfg.ready  = 1'b1;

  pba_in_reg u_in (
    .clk     (clk),
    .rst     (rst),
    .load    (load_in),
    .d       (in_word),
    .advance (advance),
    .valid   (in_valid),
    .q       (item)
  );

  pba_alloc #(
    .BARS_PER_DEVICE (BARS_PER_DEVICE)
  ) u_alloc (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg.valid && cfg.ready),
    .cfg_data (cfg.window_base),
    .advance  (advance),
    .item     (item),
    .result   (result)
  );

  pba_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (advance),
    .d     (result),
    .take  (results.ready),
    .valid (out_valid),
    .q     (out_word)
  );

  assign results.valid          = out_valid;
  assign results.action         = out_word.action;
  assign results.write_value    = out_word.write_value;
  assign results.assigned_count = out_word.assigned_count;
  assign results.next_free      = out_word.next_free;

endmodule

FILE: hw/rtl/pba_checker.sv
`include "pci_bar_window_allocator_assert.svh"

module pba_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  action,
  input logic [31:0] write_value,
  input logic [31:0] assigned_count,
  input logic [31:0] next_free
);
  import pba_pkg::*;

  logic [2:0]  last_action;
  logic [98:0] shown_word;

  assign shown_word = {action, write_value, assigned_count, next_free};

  always_ff @(posedge clk) begin
    if (rst) begin
      last_action <= ACT_KEPT;
    end else if (out_valid && out_ready) begin
      last_action <= action;
    end
  end

  `PBA_ASSERT_ALWAYS(a_reset_empties, rst |=> !out_valid)
  `PBA_ASSERT(a_valid_holds, out_valid && !out_ready |=> out_valid)
  `PBA_ASSERT(a_word_holds, out_valid && !out_ready |=> $stable(shown_word))
  `PBA_ASSERT(a_upper_follows_assign, out_valid && out_ready && action == ACT_UPPER |-> last_action == ACT_ASSIGNED)

endmodule

bind pci_bar_window_allocator pba_checker u_pba_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (results.valid),
  .out_ready      (results.ready),
  .action         (results.action),
  .write_value    (results.write_value),
  .assigned_count (results.assigned_count),
  .next_free      (results.next_free)
);
